FILE: src/bps_pkg.sv
// shared constants and types for the byte pattern search
`timescale 1ns / 1ps
package bps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam longint unsigned MAX_BUFFER = 64'd65536;

  localparam int BYTE_W = 8;
  localparam int PAT_W = MAX_PATTERN * BYTE_W;
  localparam int LEN_W = 5;
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W = $clog2(MAX_BUFFER + 64'd1);
  localparam int OFFSET_W = 16;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;

  localparam longint unsigned OFFSET_MAX = 64'd65535;
  localparam longint unsigned OFFSET_CAP =
      (MAX_BUFFER - 64'd1 > OFFSET_MAX) ? OFFSET_MAX : (MAX_BUFFER - 64'd1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;

  // control handed from the top level to every cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: src/byte_pattern_search.sv
// top level of the streaming byte pattern search
//
//   channel   signals                                           direction
//   byte      byte_valid, byte_stall, data_byte, last_byte      into the block
//   result    result_valid, result_stall, found, match_offset,
//             length_overflow                                   out of the block
//   config    cfg_write, cfg_index, cfg_data                    into the block
//
// one byte per cycle while byte_stall is low; the result appears the cycle after the marked byte.
// the output register frees the byte side: a byte is taken while a result
// waits, and byte_stall rises only when a result is held and result_stall is high.
// rst is synchronous and clears the stream state, result_valid and the
// pattern registers (length reset to one); no clearing pass.
`timescale 1ns / 1ps
module byte_pattern_search
  import bps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 found,
  output logic [OFFSET_W-1:0]  match_offset,
  output logic                 length_overflow
);

  logic [PAT_W-1:0] pattern;
  logic [LEN_W-1:0] pattern_length;

  logic [CNT_W-1:0]    bytes_seen;
  logic                match_latched;
  logic [OFFSET_W-1:0] match_start;
  logic                overflow_seen;

  logic accept;
  cell_ctrl_t ctrl;

  byte_t chain [MAX_PATTERN+1];
  byte_t expect_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] active;
  logic [MAX_PATTERN-1:0] cell_hit;

  logic [LEN_W-1:0] len_eff;
  logic             over;
  logic [CNT_W:0]   count_next;
  logic             check;
  logic             new_match;
  logic [CNT_W:0]   start_raw;
  logic [OFFSET_W-1:0] start_sat;
  logic                 found_next;
  logic [OFFSET_W-1:0]  offset_next;
  logic                 overflow_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      pattern_length <= LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pattern[63:0] <= cfg_data;
        REG_PATTERN_HIGH:   pattern[PAT_W-1:64] <= cfg_data[PAT_W-65:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
  end

  assign byte_stall = result_valid && result_stall;
  assign accept = byte_valid && !byte_stall;
  assign ctrl.shift = accept;
  assign ctrl.clear = last_byte;

  assign chain[0] = data_byte;

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [LEN_W-1:0] sel;
      // cell k lines up with pattern byte len - 1 - k
      assign sel = len_eff - LEN_W'(1) - LEN_W'(k);
      assign active[k] = LEN_W'(k) < len_eff;
      assign expect_byte[k] = pattern[BYTE_W*sel[IDX_W-1:0] +: BYTE_W];

      bps_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .byte_in    (chain[k]),
        .expect_byte(expect_byte[k]),
        .active     (active[k]),
        .byte_out   (chain[k+1]),
        .hit        (cell_hit[k])
      );
    end
  endgenerate

  always_comb begin
    over = bytes_seen >= CNT_W'(MAX_BUFFER);
    count_next = {1'b0, bytes_seen} + (CNT_W+1)'(1);
    check = !match_latched && (over || count_next >= (CNT_W+1)'(len_eff));
    new_match = check && (&cell_hit);
    start_raw = count_next - (CNT_W+1)'(len_eff);
    if (over) begin
      start_sat = OFFSET_W'(OFFSET_CAP);
    end else if (start_raw > (CNT_W+1)'(OFFSET_MAX)) begin
      start_sat = OFFSET_W'(OFFSET_MAX);
    end else begin
      start_sat = start_raw[OFFSET_W-1:0];
    end
    found_next = match_latched || new_match;
    if (match_latched) begin
      offset_next = match_start;
    end else if (new_match) begin
      offset_next = start_sat;
    end else begin
      offset_next = '0;
    end
    overflow_next = overflow_seen || over;
  end

  // stream state, back to reset after the marked byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_latched <= 1'b0;
      match_start <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        bytes_seen <= '0;
        match_latched <= 1'b0;
        match_start <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (!over) begin
          bytes_seen <= count_next[CNT_W-1:0];
        end
        match_latched <= found_next;
        match_start <= offset_next;
        overflow_seen <= overflow_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      found <= found_next;
      match_offset <= offset_next;
      length_overflow <= overflow_next;
    end
  end

endmodule

FILE: src/bps_cell.sv
// one window cell: holds a stream byte, passes it on and compares the incoming byte
`timescale 1ns / 1ps
module bps_cell
  import bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  byte_t      byte_in,
  input  byte_t      expect_byte,
  input  logic       active,
  output byte_t      byte_out,
  output logic       hit
);

  byte_t window_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_byte <= '0;
    end else if (ctrl.shift) begin
      if (ctrl.clear) begin
        window_byte <= '0;
      end else begin
        window_byte <= byte_in;
      end
    end
  end

  // compare the byte that lands here on this transfer; unused cells always agree
  assign hit = !active || (byte_in == expect_byte);
  assign byte_out = window_byte;

endmodule

FILE: tb/tb_byte_pattern_search.sv
// self-checking testbench for the streaming byte pattern search
`timescale 1ns / 1ps
module tb_byte_pattern_search;
  import bps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1150;
  localparam int MAX_GAP = 17;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic found;
    logic [OFFSET_W-1:0] offset;
    logic overflow;
  } search_result_t;

  class search_scoreboard;
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] length_reg;
    byte_t window [MAX_PATTERN];
    int unsigned seen;
    bit latched;
    logic [OFFSET_W-1:0] start;
    bit over_seen;
    search_result_t expected_results[$];
    int errors;

    function new();
      pattern = '0;
      length_reg = LEN_W'(1);
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (window[i]) window[i] = '0;
      seen = 0;
      latched = 0;
      start = '0;
      over_seen = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_PATTERN_LOW: pattern[CFG_W-1:0] = data;
        REG_PATTERN_HIGH: pattern[PAT_W-1:CFG_W] = data;
        REG_PATTERN_LENGTH: length_reg = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(byte_t b, logic lst);
      int unsigned len;
      int unsigned pos;
      int unsigned i;
      bit over;
      bit hit;
      search_result_t r;
      len = length_reg;
      if (len == 0) len = 1;
      if (len > MAX_PATTERN) len = MAX_PATTERN;
      pos = seen;
      for (i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      over = (pos >= MAX_BUFFER);
      if (over) over_seen = 1;
      else seen = pos + 1;
      if (!latched && (over || pos + 1 >= len)) begin
        hit = 1;
        for (i = 0; i < len; i++) begin
          if (window[len-1-i] != pattern[8*i +: 8]) hit = 0;
        end
        if (hit) begin
          latched = 1;
          // a match completed past the buffer limit reports the capped offset
          if (over) start = OFFSET_CAP[OFFSET_W-1:0];
          else if (pos + 1 - len > OFFSET_MAX) start = OFFSET_MAX[OFFSET_W-1:0];
          else start = OFFSET_W'(pos + 1 - len);
        end
      end
      if (lst) begin
        r.found = latched;
        r.offset = latched ? start : '0;
        r.overflow = over_seen;
        expected_results.push_back(r);
        clear_stream();
      end
    endfunction

    function void check_result(logic f, logic [OFFSET_W-1:0] off, logic ov);
      search_result_t e;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: found %0d offset %0d overflow %0d",
               f, off, ov);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (f !== e.found) begin
        $error("found: expected %0d, actual %0d", e.found, f);
        errors++;
      end
      if (off !== e.offset) begin
        $error("match_offset: expected %0d, actual %0d", e.offset, off);
        errors++;
      end
      if (ov !== e.overflow) begin
        $error("length_overflow: expected %0d, actual %0d", e.overflow, ov);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic byte_valid;
  logic byte_stall;
  logic [7:0] data_byte;
  logic last_byte;
  logic result_valid;
  logic result_stall;
  logic found;
  logic [OFFSET_W-1:0] match_offset;
  logic length_overflow;

  search_scoreboard sb;
  int items_sent;
  int idle_cycles;
  logic [PAT_W-1:0] pat_bits;
  int eff_len;

  byte_pattern_search dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .found(found),
    .match_offset(match_offset),
    .length_overflow(length_overflow)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_byte(input byte_t b, input logic lst, input int gap);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sb.note_byte(b, lst);
    items_sent++;
  endtask

  task automatic send_buffer(input byte_t bytes[$], input bit no_gaps);
    bit burst;
    int gap;
    burst = no_gaps || ($urandom_range(0, 3) == 0);
    foreach (bytes[k]) begin
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      send_byte(bytes[k], k == bytes.size() - 1, gap);
    end
  endtask

  // valid stays high across buffers, so it is lowered only here and before a gap in send_byte
  task automatic drain();
    byte_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_register(idx, data);
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                           input logic [LEN_W-1:0] len_field);
    logic [CFG_W-1:0] len_word;
    drain();
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = len_field;
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, len_word);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    pat_bits = {hi, lo};
    eff_len = (len_field == 0) ? 1 : (len_field > MAX_PATTERN) ? MAX_PATTERN : len_field;
  endtask

  function automatic byte_t pick_byte();
    if ($urandom_range(0, 9) < 7) return pat_bits[8*$urandom_range(0, eff_len - 1) +: 8];
    return byte_t'($urandom);
  endfunction

  // mostly buffers that carry the pattern, some noise, some broken or cut-off copies
  task automatic build_buffer(output byte_t bytes[$]);
    int blen;
    int kind;
    int at;
    int j;
    blen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60)
                                       : $urandom_range(1, 2 * eff_len + 6);
    kind = $urandom_range(0, 9);
    bytes = {};
    for (j = 0; j < blen; j++) bytes.push_back(kind < 2 ? byte_t'($urandom) : pick_byte());
    if (kind >= 2 && blen >= eff_len) begin
      if (kind == 7) begin
        at = blen - (eff_len - 1);
        for (j = 0; j < eff_len - 1; j++) bytes[at+j] = pat_bits[8*j +: 8];
      end else begin
        at = $urandom_range(0, blen - eff_len);
        for (j = 0; j < eff_len; j++) bytes[at+j] = pat_bits[8*j +: 8];
        if (kind == 8) begin
          at = $urandom_range(0, blen - eff_len);
          for (j = 0; j < eff_len; j++) bytes[at+j] = pat_bits[8*j +: 8];
        end
        if (kind == 9) begin
          j = $urandom_range(0, eff_len - 1);
          bytes[at+j] = bytes[at+j] ^ byte_t'(1 << $urandom_range(0, 7));
        end
      end
    end
  endtask

  // result side: a fresh stall length is drawn after every transfer
  initial begin
    int n;
    result_stall = 1'b0;
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (result_valid && !result_stall) sb.check_result(found, match_offset, length_overflow);
      if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    byte_t q[$];
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [LEN_W-1:0] len_field;
    int sel;
    int k;
    sb = new();
    items_sent = 0;
    pat_bits = '0;
    eff_len = 1;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    byte_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset pattern is a single zero byte
    q = '{8'h00};
    send_buffer(q, 0);
    q = '{8'hFF};
    send_buffer(q, 0);
    q = '{8'hFF, 8'h00};
    send_buffer(q, 0);

    // length zero acts as one
    configure(64'hAB, 64'h0, 5'd0);
    q = '{8'h12, 8'hAB};
    send_buffer(q, 0);

    // full-length pattern with zero bytes in it
    configure('1, '0, 5'd16);
    q = {};
    for (k = 0; k < 16; k++) q.push_back(k < 8 ? 8'hFF : 8'h00);
    send_buffer(q, 0);

    // oversized length clamps to sixteen; buffer too short to match
    configure('1, '0, 5'd31);
    q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer(q, 0);

    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 7);
      lo = (sel == 0) ? '1 : (sel == 1) ? '0 : {$urandom, $urandom};
      hi = (sel == 0) ? '1 : (sel == 1) ? '0 : {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      case (sel)
        0: len_field = 5'd1;
        1: len_field = 5'd16;
        2: len_field = 5'd0;
        3: len_field = LEN_W'($urandom_range(17, 31));
        default: len_field = LEN_W'($urandom_range(2, 15));
      endcase
      configure(lo, hi, len_field);
      repeat ($urandom_range(3, 8)) begin
        build_buffer(q);
        send_buffer(q, 0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d expected results never arrived", sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
src/bps_pkg.sv
src/bps_cell.sv
src/byte_pattern_search.sv
tb/tb_byte_pattern_search.sv
